@@ hw/rtl/sfrd_pkg.sv @@
// Shared types and constants for the sync frame receiver with dead-man timeout.
// Used by sfrd_parser, sfrd_deadman and sync_frame_receiver_deadman_top.
`timescale 1ns / 1ps
`default_nettype none
package sfrd_pkg;

    // Input operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_BOARD_INDEX    = 2'd0;
    localparam logic [1:0] CFG_DEADMAN_ENABLE = 2'd1;
    localparam logic [1:0] CFG_DEADMAN_TICKS  = 2'd2;

    // Header bytes and frame types
    localparam logic [7:0] HDR_A       = 8'hFF;
    localparam logic [7:0] HDR_B       = 8'h00;
    localparam logic [7:0] TYPE_LEVELS = 8'd1;
    localparam logic [7:0] TYPE_KEEP   = 8'd2;

    localparam int FIRST_PAYLOAD_POS = 5;
    localparam logic [3:0] MAX_BOARD = 4'd9;

    localparam logic [15:0] DEADMAN_TICKS_RESET = 16'd500;

    typedef struct packed {
        logic [3:0]  board_index;
        logic        deadman_enable;
        logic [15:0] deadman_ticks;
    } cfg_t;

    // Parser result for the item in process
    typedef struct packed {
        logic        done;        // this byte completed a frame
        logic [15:0] count_next;  // frame count after this item
        logic [7:0]  level_0;     // latched brightness, channel 0
        logic [7:0]  level_1;     // latched brightness, channel 1
    } frame_status_t;

endpackage
`default_nettype wire

@@ hw/rtl/sync_frame_receiver_deadman_top.sv @@
// Top level of the sync frame receiver with dead-man timeout.
// Instantiates sfrd_parser and sfrd_deadman; depends on sfrd_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Takes one request per cycle: either a received serial byte or a 1 ms tick,
// and returns exactly one result per request, in order. Each request is
// captured in an input register, processed by one pass of short logic
// (header match, position compare, saturating counter) and stored in a
// result register, from which it is presented; throughput is one request
// per clock as long as the result side keeps taking results; while a
// result waits, the input register still holds one more request.
// Frames open on FF 00 FF 00 followed by type 1 or 2 and run to byte
// FRAME_LAST_INDEX; type 1 frames latch this board's brightness pair.
// Drive values change only on ticks, and drop to zero once the dead-man
// count reaches deadman_ticks while enabled. Config writes are always
// accepted and must only be issued while the block is idle.
module sync_frame_receiver_deadman_top #(
    parameter int PAYLOAD_BYTES    = 20,
    parameter int FRAME_LAST_INDEX = 25
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        operation,
    input  wire logic [7:0]  data_byte,
    // result channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       drive_0,
    output logic [7:0]       drive_1,
    output logic             frame_done,
    output logic [15:0]      frames_received,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import sfrd_pkg::*;

    // input register
    logic       in_valid_reg;
    logic       op_reg;
    logic [7:0] byte_reg;

    // result register
    logic        out_valid_reg;
    logic [7:0]  drive0_out_reg, drive1_out_reg;
    logic        done_out_reg;
    logic [15:0] count_out_reg;

    cfg_t          cfg_reg;
    frame_status_t status;
    logic          advance;
    logic          byte_step, tick_step;
    logic [7:0]    drive_0_next, drive_1_next;

    // process the held request when the result slot is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign byte_step = advance && (op_reg == OP_BYTE);
    assign tick_step = advance && (op_reg == OP_TICK);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg   <= operation;
            byte_reg <= data_byte;
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.board_index    <= '0;
            cfg_reg.deadman_enable <= 1'b1;
            cfg_reg.deadman_ticks  <= DEADMAN_TICKS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BOARD_INDEX:    cfg_reg.board_index    <= cfg_data[3:0];
                CFG_DEADMAN_ENABLE: cfg_reg.deadman_enable <= cfg_data[0];
                CFG_DEADMAN_TICKS:  cfg_reg.deadman_ticks  <= cfg_data;
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    sfrd_parser #(
        .PAYLOAD_BYTES    (PAYLOAD_BYTES),
        .FRAME_LAST_INDEX (FRAME_LAST_INDEX)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_step   (byte_step),
        .data_byte   (byte_reg),
        .board_index (cfg_reg.board_index),
        .status      (status)
    );

    sfrd_deadman u_deadman (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_step    (tick_step),
        .status       (status),
        .cfg          (cfg_reg),
        .drive_0_next (drive_0_next),
        .drive_1_next (drive_1_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drive0_out_reg <= drive_0_next;
            drive1_out_reg <= drive_1_next;
            done_out_reg   <= status.done;
            count_out_reg  <= status.count_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign drive_0         = drive0_out_reg;
    assign drive_1         = drive1_out_reg;
    assign frame_done      = done_out_reg;
    assign frames_received = count_out_reg;

endmodule
`default_nettype wire

@@ hw/rtl/sfrd_parser.sv @@
// Header search, frame collection, brightness capture and frame count.
// Depends on sfrd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfrd_parser #(
    parameter int PAYLOAD_BYTES    = 20,
    parameter int FRAME_LAST_INDEX = 25
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   byte_step,
    input  wire logic [7:0]             data_byte,
    input  wire logic [3:0]             board_index,
    output sfrd_pkg::frame_status_t     status
);
    import sfrd_pkg::*;

    localparam int POS_W  = $clog2(FRAME_LAST_INDEX + 1);
    localparam int PAY_W  = $clog2(PAYLOAD_BYTES + 1);
    localparam int CMP_A  = (POS_W > PAY_W) ? POS_W : PAY_W;
    localparam int CMP_W  = (CMP_A > 5) ? CMP_A : 5;
    localparam logic [POS_W-1:0] FIRST_POS = POS_W'(FIRST_PAYLOAD_POS);
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_LAST_INDEX);

    logic [7:0]       window_reg [5];
    logic [7:0]       window_next [5];
    logic             in_frame_reg, in_frame_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       pend0_reg, pend0_next, pend1_reg, pend1_next;
    logic [7:0]       lat0_reg, lat0_next, lat1_reg, lat1_next;
    logic [15:0]      count_reg, count_next;
    logic             done;

    logic [3:0]       board_lim;
    logic [CMP_W-1:0] base, idx;

    assign board_lim = (board_index > MAX_BOARD) ? MAX_BOARD : board_index;
    assign base      = CMP_W'({board_lim, 1'b0});
    assign idx       = CMP_W'(pos_reg) - CMP_W'(FIRST_POS);

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            window_next[i] = window_reg[i];
        end
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        type_next     = type_reg;
        pend0_next    = pend0_reg;
        pend1_next    = pend1_reg;
        lat0_next     = lat0_reg;
        lat1_next     = lat1_reg;
        count_next    = count_reg;
        done          = 1'b0;

        if (byte_step)
        begin
            if (!in_frame_reg)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    window_next[i] = window_reg[i + 1];
                end
                window_next[4] = data_byte;
                if (window_reg[1] == HDR_A && window_reg[2] == HDR_B &&
                    window_reg[3] == HDR_A && window_reg[4] == HDR_B &&
                    (data_byte == TYPE_LEVELS || data_byte == TYPE_KEEP))
                begin
                    in_frame_next = 1'b1;
                    pos_next      = FIRST_POS;
                    type_next     = data_byte;
                    pend0_next    = '0;
                    pend1_next    = '0;
                end
            end
            else
            begin
                if (idx < CMP_W'(PAYLOAD_BYTES))
                begin
                    if (idx == base)
                    begin
                        pend0_next = data_byte;
                    end
                    else if (idx == base + CMP_W'(1))
                    begin
                        pend1_next = data_byte;
                    end
                end
                if (pos_reg >= LAST_POS)
                begin
                    in_frame_next = 1'b0;
                    pos_next      = '0;
                    if (type_reg == TYPE_LEVELS)
                    begin
                        lat0_next = pend0_next;
                        lat1_next = pend1_next;
                    end
                    count_next = count_reg + 16'd1;
                    done       = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
            begin
                window_reg[i] <= '0;
            end
            in_frame_reg <= 1'b0;
            pos_reg      <= '0;
            type_reg     <= '0;
            pend0_reg    <= '0;
            pend1_reg    <= '0;
            lat0_reg     <= '0;
            lat1_reg     <= '0;
            count_reg    <= '0;
        end
        else
        begin
            for (int i = 0; i < 5; i++)
            begin
                window_reg[i] <= window_next[i];
            end
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            type_reg     <= type_next;
            pend0_reg    <= pend0_next;
            pend1_reg    <= pend1_next;
            lat0_reg     <= lat0_next;
            lat1_reg     <= lat1_next;
            count_reg    <= count_next;
        end
    end

    assign status.done       = done;
    assign status.count_next = count_next;
    assign status.level_0    = lat0_reg;
    assign status.level_1    = lat1_reg;

endmodule
`default_nettype wire

@@ hw/rtl/sfrd_deadman.sv @@
// Dead-man tick counter, cleared when a frame completes, and drive registers, updated on tick items.
// Depends on sfrd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sfrd_deadman (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   tick_step,
    input  sfrd_pkg::frame_status_t     status,
    input  sfrd_pkg::cfg_t              cfg,
    output logic [7:0]                  drive_0_next,
    output logic [7:0]                  drive_1_next
);
    import sfrd_pkg::*;

    logic [15:0] ticks_reg, ticks_next, ticks_inc;
    logic [7:0]  drive0_reg, drive1_reg;
    logic        expired;

    // saturating count
    assign ticks_inc = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;
    assign expired   = cfg.deadman_enable && (ticks_inc >= cfg.deadman_ticks);

    always_comb
    begin
        ticks_next   = ticks_reg;
        drive_0_next = drive0_reg;
        drive_1_next = drive1_reg;
        if (status.done)
        begin
            ticks_next = '0;
        end
        else if (tick_step)
        begin
            ticks_next   = ticks_inc;
            drive_0_next = expired ? 8'd0 : status.level_0;
            drive_1_next = expired ? 8'd0 : status.level_1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg  <= '0;
            drive0_reg <= '0;
            drive1_reg <= '0;
        end
        else
        begin
            ticks_reg  <= ticks_next;
            drive0_reg <= drive_0_next;
            drive1_reg <= drive_1_next;
        end
    end

endmodule
`default_nettype wire

@@ tb/tb_sync_frame_receiver_deadman_top.sv @@
// Testbench for sync_frame_receiver_deadman_top: streams serial bytes and 1 ms ticks,
// predicts every result in step and checks each field of each result in order.
// Depends on sfrd_pkg and the top-level RTL; nothing else.
`timescale 1ns / 1ps
module tb_sync_frame_receiver_deadman_top;
    import sfrd_pkg::*;

    localparam int PAYLOAD_BYTES    = 20;
    localparam int FRAME_LAST_INDEX = 25;
    localparam int FRAME_BODY       = FRAME_LAST_INDEX - FIRST_PAYLOAD_POS + 1; // payload + checksum
    localparam int STALL_LIMIT      = 5000;
    localparam int TAIL_CYCLES      = 10;
    localparam logic [7:0] FILL_BYTE = 8'h55; // never part of a header

    // One request: a serial byte or a tick
    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } req_t;

    // Expected result of one request
    typedef struct packed {
        logic [7:0]  d0;
        logic [7:0]  d1;
        logic        done;
        logic [15:0] count;
    } drive_status_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic        operation = OP_BYTE;
    logic [7:0]  data_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  drive_0;
    logic [7:0]  drive_1;
    logic        frame_done;
    logic [15:0] frames_received;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_BOARD_INDEX;
    logic [15:0] cfg_data  = 16'h0000;

    sync_frame_receiver_deadman_top #(
        .PAYLOAD_BYTES    (PAYLOAD_BYTES),
        .FRAME_LAST_INDEX (FRAME_LAST_INDEX)
    ) uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .data_byte       (data_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .drive_0         (drive_0),
        .drive_1         (drive_1),
        .frame_done      (frame_done),
        .frames_received (frames_received),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the receiver and its registers
    // ------------------------------------------------------------------
    logic [3:0]  board_sel  = 4'd0;
    logic        dm_enable  = 1'b1;
    logic [15:0] dm_limit   = DEADMAN_TICKS_RESET;

    logic [7:0]  rx_window [5] = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    logic        frame_open   = 1'b0;
    logic [4:0]  frame_pos    = 5'd0;
    logic [7:0]  frame_kind   = 8'h00;
    logic [7:0]  pend_level [2] = '{8'h00, 8'h00};
    logic [7:0]  held_level [2] = '{8'h00, 8'h00};
    logic [7:0]  drv_level  [2] = '{8'h00, 8'h00};
    logic [15:0] quiet_ticks  = 16'd0;
    logic [15:0] frame_total  = 16'd0;

    req_t          req_q [$];      // requests waiting to be driven
    drive_status_t status_q [$];   // predicted results, oldest first
    req_t          next_req;
    drive_status_t want;

    int send_gap_pct = 20;
    int take_gap_pct = 75;
    int error_count  = 0;
    int stall_cycles = 0;

    // Advance the private receiver by one request and return what the
    // block must report for it.
    function automatic drive_status_t predict_status(input logic op, input logic [7:0] b);
        drive_status_t st;
        int idx;
        int base;
        st.done = 1'b0;
        if (op == OP_BYTE)
        begin
            if (!frame_open)
            begin
                for (int i = 0; i < 4; i++)
                    rx_window[i] = rx_window[i + 1];
                rx_window[4] = b;
                if (rx_window[0] == HDR_A && rx_window[1] == HDR_B &&
                    rx_window[2] == HDR_A && rx_window[3] == HDR_B &&
                    (rx_window[4] == TYPE_LEVELS || rx_window[4] == TYPE_KEEP))
                begin
                    frame_open    = 1'b1;
                    frame_pos     = 5'(FIRST_PAYLOAD_POS);
                    frame_kind    = rx_window[4];
                    pend_level[0] = 8'h00;
                    pend_level[1] = 8'h00;
                end
            end
            else
            begin
                // board index above 9 behaves as 9
                idx  = int'(frame_pos) - FIRST_PAYLOAD_POS;
                base = 2 * int'((board_sel > MAX_BOARD) ? MAX_BOARD : board_sel);
                if (idx < PAYLOAD_BYTES)
                begin
                    if (idx == base)
                        pend_level[0] = b;
                    else if (idx == base + 1)
                        pend_level[1] = b;
                end
                if (int'(frame_pos) >= FRAME_LAST_INDEX)
                begin
                    // checksum byte: frame complete, window left as it was
                    frame_open = 1'b0;
                    frame_pos  = 5'd0;
                    if (frame_kind == TYPE_LEVELS)
                    begin
                        held_level[0] = pend_level[0];
                        held_level[1] = pend_level[1];
                    end
                    quiet_ticks = 16'd0;
                    frame_total = frame_total + 16'd1;
                    st.done     = 1'b1;
                end
                else
                    frame_pos = frame_pos + 5'd1;
            end
        end
        else
        begin
            if (quiet_ticks != 16'hFFFF)
                quiet_ticks = quiet_ticks + 16'd1;
            // a limit of zero counts as expired at once
            if (dm_enable && quiet_ticks >= dm_limit)
            begin
                drv_level[0] = 8'h00;
                drv_level[1] = 8'h00;
            end
            else
            begin
                drv_level[0] = held_level[0];
                drv_level[1] = held_level[1];
            end
        end
        st.d0    = drv_level[0];
        st.d1    = drv_level[1];
        st.count = frame_total;
        return st;
    endfunction

    task automatic flag_error(input string what, input int got, input int exp_val);
        $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, exp_val);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Request driver: presents queued requests, holds each until taken,
    // and predicts the result at the edge the request is accepted.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            operation <= OP_BYTE;
            data_byte <= 8'h00;
        end
        else
        begin
            if (in_valid && in_ready)
                status_q.push_back(predict_status(operation, data_byte));
            if (!in_valid || in_ready)
            begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    next_req  = req_q.pop_front();
                    in_valid  <= 1'b1;
                    operation <= next_req.op;
                    data_byte <= next_req.data;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, in-order field compare
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (status_q.size() == 0)
                    flag_error("result with no request waiting, frames_received",
                               frames_received, -1);
                else
                begin
                    want = status_q.pop_front();
                    if (drive_0 !== want.d0)
                        flag_error("drive_0", drive_0, want.d0);
                    if (drive_1 !== want.d1)
                        flag_error("drive_1", drive_1, want.d1);
                    if (frame_done !== want.done)
                        flag_error("frame_done", frame_done, want.done);
                    if (frames_received !== want.count)
                        flag_error("frames_received", frames_received, want.count);
                end
            end
            out_ready <= ($urandom_range(99) >= take_gap_pct);
        end
    end

    // Watchdog: ends the run after too many cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0)
            return 8'h00;
        else if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic push_byte(input logic [7:0] b);
        req_t r;
        r.op   = OP_BYTE;
        r.data = b;
        req_q.push_back(r);
    endtask

    task automatic push_tick();
        req_t r;
        r.op   = OP_TICK;
        r.data = 8'($urandom_range(255)); // don't care, but exercised
        req_q.push_back(r);
    endtask

    task automatic push_header(input logic [7:0] kind);
        push_byte(HDR_A);
        push_byte(HDR_B);
        push_byte(HDR_A);
        push_byte(HDR_B);
        push_byte(kind);
    endtask

    // Header, type and body_len frame bytes with ticks sprinkled in.
    // A short body leaves the frame open; later bytes then complete it.
    task automatic queue_frame(input logic [7:0] kind, input int body_len);
        push_header(kind);
        for (int i = 0; i < body_len; i++)
        begin
            if ($urandom_range(5) == 0)
                push_tick();
            push_byte(rand_byte());
        end
    endtask

    // Mostly well-formed frames, plus tick bursts, unknown types,
    // broken headers and noise
    task automatic queue_random_mix(input int n);
        int goal;
        int pick;
        logic [7:0] kind;
        goal = req_q.size() + n;
        while (req_q.size() < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                queue_frame((pick < 42) ? TYPE_LEVELS : TYPE_KEEP, FRAME_BODY);
            else if (pick < 60)
                queue_frame(TYPE_LEVELS, $urandom_range(FRAME_BODY - 1, 1));
            else if (pick < 72)
                repeat ($urandom_range(15, 1)) push_tick();
            else if (pick < 80)
            begin
                kind = 8'($urandom_range(255));
                if (kind == TYPE_LEVELS || kind == TYPE_KEEP)
                    kind = 8'h00;
                push_header(kind);
            end
            else if (pick < 90)
            begin
                // header cut short, or slipped by one pair
                push_byte(HDR_A);
                push_byte(HDR_B);
                if ($urandom_range(1) == 0)
                    push_byte(HDR_A);
                else
                    push_header(TYPE_LEVELS);
                push_byte(rand_byte());
            end
            else
                repeat ($urandom_range(6, 1))
                begin
                    if ($urandom_range(2) == 0)
                        push_tick();
                    else
                        push_byte(rand_byte());
                end
        end
    endtask

    // Wait until every request is taken and every result is back
    task automatic drain();
        do
            @(negedge clk);
        while (req_q.size() != 0 || in_valid || status_q.size() != 0);
        @(posedge clk);
    endtask

    // Register write; cfg_valid is left high for a following write
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_BOARD_INDEX:    board_sel = val[3:0];
            CFG_DEADMAN_ENABLE: dm_enable = val[0];
            CFG_DEADMAN_TICKS:  dm_limit  = val;
            default: ;
        endcase
    endtask

    // Only called with the block idle
    task automatic set_regs(input logic [3:0] board, input logic en, input logic [15:0] ticks);
        write_reg(CFG_BOARD_INDEX, 16'(board));
        write_reg(CFG_DEADMAN_ENABLE, 16'(en));
        write_reg(CFG_DEADMAN_TICKS, ticks);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, under reset register values: both operations, bytes with
        // extreme data, and headers with unknown types (no frame opens)
        push_tick();
        push_byte(8'h00);
        push_byte(8'hFF);
        push_tick();
        push_header(8'h03);
        push_tick();
        push_header(8'h00);
        push_header(8'hFF);
        push_tick();
        drain();

        // Sender idles 20%, receiver 75%
        set_regs(4'd3, 1'b1, 16'd6);
        queue_random_mix(160);
        drain();                     // sender held off until all results are in
        queue_random_mix(160);
        queue_frame(TYPE_LEVELS, 8); // leave a frame open across the register change
        drain();

        // Sender idles 75%, receiver 20%
        send_gap_pct = 75;
        take_gap_pct = 20;
        set_regs(4'd15, 1'b1, 16'd0); // out-of-range board, zero timeout
        queue_random_mix(120);
        drain();
        set_regs(4'd0, 1'b0, 16'd1);  // dead-man off
        queue_random_mix(160);
        drain();

        // No idling on either side
        send_gap_pct = 0;
        take_gap_pct = 0;
        set_regs(4'd9, 1'b1, 16'd7);
        queue_random_mix(200);
        drain();

        // Longest timeout: drives keep following the latched levels
        set_regs(4'd5, 1'b1, 16'hFFFF);
        repeat (FRAME_BODY) push_byte(FILL_BYTE); // closes any open frame
        queue_frame(TYPE_LEVELS, FRAME_BODY);
        repeat (30) push_tick();
        queue_frame(TYPE_LEVELS, FRAME_BODY);
        repeat (3) push_tick();
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && status_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/sfrd_pkg.sv
hw/rtl/sfrd_parser.sv
hw/rtl/sfrd_deadman.sv
hw/rtl/sync_frame_receiver_deadman_top.sv
tb/tb_sync_frame_receiver_deadman_top.sv
